FILE: hw/rtl/iocr_pkg.sv
// Shared types and constants for the in-order completion ring.
// Used by iocr_store and in_order_completion_ring; depends on nothing.
`timescale 1ns / 1ps

package iocr_pkg;

    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 4;
    localparam int ITEM_OUT_W = 32;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_COMPLETE = 2'd2,
        MODE_CLOSE    = 2'd3
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 4'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FINISHED   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_RETIRED    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_HELD       = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BADSLOT    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_CLOSED     = 4'd8;

    // Write and read strobes, and the done-mark write data, for the slot storage.
    typedef struct packed {
        logic pay_we;
        logic done_we;
        logic done_wdata;
        logic rd_en;
    } store_ctl_t;

endpackage

FILE: hw/rtl/in_order_completion_ring.sv
// In-order completion ring: add, dispatch, complete and close on a ring of slots.
// Add, close and a rejected complete load their result from the send state; a dispatch
// first reads the payload, and a complete reads and checks each retired slot in turn. A
// stalled result waits until m_ready. The next transfer is taken once the final result
// is loaded. Reset (aresetn low, synchronous) clears state, pointers, closed flag and
// output valid; slot memories and result registers are not cleared.
`timescale 1ns / 1ps

module in_order_completion_ring
    import iocr_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [ITEM_OUT_W-1:0] s_payload,
    input  logic [SLOT_W-1:0]     s_slot,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [SLOT_W-1:0]     m_slot_index,
    output logic [ITEM_OUT_W-1:0] m_item,
    output logic                  m_last,
    output logic                  m_drained
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_RET_RD,
        S_RET_CHK,
        S_SEND
    } state_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W:0] ring_dist(input logic [PTR_W-1:0] from,
                                                 input logic [PTR_W-1:0] to);
        logic [PTR_W:0] d;
        if (to >= from) begin
            d = {1'b0, to} - {1'b0, from};
        end else begin
            d = {1'b0, to} + (PTR_W+1)'(DEPTH) - {1'b0, from};
        end
        return d;
    endfunction

    state_t                 state_reg;
    logic [PTR_W-1:0]       aptr_reg;
    logic [PTR_W-1:0]       dptr_reg;
    logic [PTR_W-1:0]       rptr_reg;
    logic                   closed_reg;
    logic [PTR_W-1:0]       cnt_reg;
    logic                   pend_reg;

    logic [STATUS_W-1:0]    res_status_reg;
    logic [SLOT_W-1:0]      res_index_reg;
    logic [ITEM_OUT_W-1:0]  res_item_reg;
    logic                   res_drained_reg;

    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [SLOT_W-1:0]      m_slot_index_reg;
    logic [ITEM_OUT_W-1:0]  m_item_reg;
    logic                   m_last_reg;
    logic                   m_drained_reg;

    store_ctl_t             ctl;
    logic [PTR_W-1:0]       done_waddr;
    logic [PTR_W-1:0]       rd_addr;
    logic [ITEM_WIDTH-1:0]  rd_payload;
    logic                   rd_done;

    mode_t                  mode;
    logic                   accept;
    logic                   out_free;
    logic                   full;
    logic                   cpl_ok;
    logic [PTR_W-1:0]       slot_p;
    logic                   drained_now;
    logic                   ret_more;
    logic                   ret_adv;
    logic                   m_load;

    assign mode     = mode_t'(s_mode);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign full        = (ring_next(aptr_reg) == rptr_reg);
    assign slot_p      = s_slot[PTR_W-1:0];
    assign cpl_ok      = ({1'b0, s_slot} < (SLOT_W+1)'(DEPTH))
                         && (ring_dist(rptr_reg, slot_p) < ring_dist(rptr_reg, dptr_reg));
    assign drained_now = closed_reg && (rptr_reg == aptr_reg);

    // Read data in the retire state always belongs to the slot at the retire pointer.
    assign ret_more = (rptr_reg != dptr_reg) && rd_done && (cnt_reg != PTR_LAST);
    assign ret_adv  = (state_reg == S_RET_CHK) && ret_more && (!pend_reg || out_free);

    // The output register takes a new result in this cycle.
    assign m_load   = ((state_reg == S_SEND) && out_free) || (ret_adv && pend_reg);

    always_comb begin
        ctl        = '0;
        done_waddr = aptr_reg;
        rd_addr    = rptr_reg;
        if (accept) begin
            unique case (mode)
                MODE_ADD: begin
                    ctl.pay_we  = !closed_reg && !full;
                    ctl.done_we = !closed_reg && !full;
                end
                MODE_DISPATCH: begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = dptr_reg;
                end
                MODE_COMPLETE: begin
                    ctl.done_we    = cpl_ok;
                    ctl.done_wdata = 1'b1;
                    done_waddr     = slot_p;
                end
                MODE_CLOSE: begin
                    ctl = '0;
                end
                default: begin
                    ctl = '0;
                end
            endcase
        end else if (state_reg == S_RET_RD) begin
            ctl.rd_en = 1'b1;
        end else if (ret_adv) begin
            // Clear the mark of the slot leaving and fetch the one after it.
            ctl.done_we = 1'b1;
            done_waddr  = rptr_reg;
            ctl.rd_en   = 1'b1;
            rd_addr     = ring_next(rptr_reg);
        end
    end

    iocr_store #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_store (
        .aclk       (aclk),
        .ctl        (ctl),
        .pay_waddr  (aptr_reg),
        .pay_wdata  (ITEM_WIDTH'(s_payload)),
        .done_waddr (done_waddr),
        .rd_addr    (rd_addr),
        .rd_payload (rd_payload),
        .rd_done    (rd_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            aptr_reg    <= '0;
            dptr_reg    <= '0;
            rptr_reg    <= '0;
            closed_reg  <= 1'b0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_item_reg    <= '0;
                        // A close reports drained against the flag it sets.
                        res_drained_reg <= (mode == MODE_CLOSE) ? (rptr_reg == aptr_reg)
                                                                : drained_now;
                        unique case (mode)
                            MODE_ADD: begin
                                res_index_reg <= SLOT_W'(aptr_reg);
                                state_reg     <= S_SEND;
                                if (closed_reg) begin
                                    res_status_reg <= ST_CLOSED;
                                end else if (full) begin
                                    res_status_reg <= ST_FULL;
                                end else begin
                                    res_status_reg <= ST_ACCEPTED;
                                    aptr_reg       <= ring_next(aptr_reg);
                                end
                            end
                            MODE_DISPATCH: begin
                                res_index_reg <= SLOT_W'(dptr_reg);
                                if (dptr_reg == aptr_reg) begin
                                    res_status_reg <= closed_reg ? ST_FINISHED : ST_EMPTY;
                                    state_reg      <= S_SEND;
                                end else begin
                                    res_status_reg <= ST_DISPATCHED;
                                    dptr_reg       <= ring_next(dptr_reg);
                                    state_reg      <= S_DISP;
                                end
                            end
                            MODE_COMPLETE: begin
                                res_index_reg <= s_slot;
                                if (cpl_ok) begin
                                    cnt_reg   <= '0;
                                    pend_reg  <= 1'b0;
                                    state_reg <= S_RET_RD;
                                end else begin
                                    res_status_reg <= ST_BADSLOT;
                                    state_reg      <= S_SEND;
                                end
                            end
                            MODE_CLOSE: begin
                                closed_reg     <= 1'b1;
                                res_status_reg <= ST_CLOSED;
                                res_index_reg  <= '0;
                                state_reg      <= S_SEND;
                            end
                            default: begin
                                state_reg <= S_SEND;
                            end
                        endcase
                    end
                end
                S_DISP: begin
                    res_item_reg <= ITEM_OUT_W'(rd_payload);
                    state_reg    <= S_SEND;
                end
                S_RET_RD: begin
                    state_reg <= S_RET_CHK;
                end
                S_RET_CHK: begin
                    if (ret_more) begin
                        // Each retired result is held back until the next is known, so that the final one can
                        // carry the last and drained marks.
                        if (ret_adv) begin
                            if (pend_reg) begin
                                m_valid_reg      <= 1'b1;
                                m_status_reg     <= res_status_reg;
                                m_slot_index_reg <= res_index_reg;
                                m_item_reg       <= res_item_reg;
                                m_last_reg       <= 1'b0;
                                m_drained_reg    <= 1'b0;
                            end
                            res_status_reg <= ST_RETIRED;
                            res_index_reg  <= SLOT_W'(rptr_reg);
                            res_item_reg   <= ITEM_OUT_W'(rd_payload);
                            pend_reg       <= 1'b1;
                            rptr_reg       <= ring_next(rptr_reg);
                            cnt_reg        <= cnt_reg + 1'b1;
                        end
                    end else begin
                        res_drained_reg <= drained_now;
                        if (!pend_reg) begin
                            res_status_reg <= ST_HELD;
                            res_item_reg   <= '0;
                        end
                        state_reg <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= res_status_reg;
                        m_slot_index_reg <= res_index_reg;
                        m_item_reg       <= res_item_reg;
                        m_last_reg       <= 1'b1;
                        m_drained_reg    <= res_drained_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_index_reg;
    assign m_item       = m_item_reg;
    assign m_last       = m_last_reg;
    assign m_drained    = m_drained_reg;

endmodule

FILE: hw/rtl/iocr_store.sv
// Slot storage of the completion ring: payload memory and done-mark memory.
// One write port each, one shared read address with registered read data. Uses iocr_pkg.
`timescale 1ns / 1ps

module iocr_store
    import iocr_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                     aclk,
    input  store_ctl_t               ctl,
    input  logic [$clog2(DEPTH)-1:0] pay_waddr,
    input  logic [ITEM_WIDTH-1:0]    pay_wdata,
    input  logic [$clog2(DEPTH)-1:0] done_waddr,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ITEM_WIDTH-1:0]    rd_payload,
    output logic                     rd_done
);

    logic [ITEM_WIDTH-1:0] pay_mem [DEPTH];
    logic                  done_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rd_payload_reg;
    logic                  rd_done_reg;

    always_ff @(posedge aclk) begin
        if (ctl.pay_we) begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        if (ctl.done_we) begin
            done_mem[done_waddr] <= ctl.done_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_payload_reg <= pay_mem[rd_addr];
            rd_done_reg    <= done_mem[rd_addr];
        end
    end

    assign rd_payload = rd_payload_reg;
    assign rd_done    = rd_done_reg;

endmodule
